### rtl/core/wsp_pdu_deframer_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef WSP_PDU_DEFRAMER_MACROS_SVH
`define WSP_PDU_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WSPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WSPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wspd_pkg.sv
// Types and constants of the WSP PDU deframer.
package wspd_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TYPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH_TYPE  = 8'd1;

  localparam logic [7:0] REPLY_TYPE_RST = 8'd4;
  localparam logic [7:0] PUSH_TYPE_RST  = 8'd6;

  // uintvar length field is at most five octets
  localparam logic [2:0] UV_MAX_OCTETS = 3'd5;

  localparam logic [2:0] KIND_TID     = 3'd0;
  localparam logic [2:0] KIND_TYPE    = 3'd1;
  localparam logic [2:0] KIND_STATUS  = 3'd2;
  localparam logic [2:0] KIND_LEN     = 3'd3;
  localparam logic [2:0] KIND_HDR     = 3'd4;
  localparam logic [2:0] KIND_BODY    = 3'd5;
  localparam logic [2:0] KIND_DISCARD = 3'd6;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SHORT   = 3'd1;
  localparam logic [2:0] ERR_TYPE    = 3'd2;
  localparam logic [2:0] ERR_UINTVAR = 3'd3;
  localparam logic [2:0] ERR_OVERRUN = 3'd4;

  localparam logic PDU_REPLY = 1'b0;
  localparam logic PDU_PUSH  = 1'b1;

  typedef enum logic [2:0] {
    PH_TID,
    PH_TYPE,
    PH_STATUS,
    PH_LEN,
    PH_HDR,
    PH_BODY,
    PH_DISCARD
  } phase_t;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       last_byte;
  } wspd_in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  field_kind;
    logic        pdu_end;
    logic [2:0]  error_code;
    logic        pdu_kind;
    logic [7:0]  transaction_id;
    logic [31:0] header_length;
  } wspd_out_t;

  typedef struct packed {
    logic [7:0] reply_type_code;
    logic [7:0] push_type_code;
  } wspd_cfg_t;

endpackage

### rtl/core/wspd_cfg_regs.sv
// Configuration registers: reply and push type codes.
module wspd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output wspd_pkg::wspd_cfg_t           cfg_o
);
  import wspd_pkg::*;

  logic [7:0] reply_code_r;
  logic [7:0] push_code_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_code_r <= REPLY_TYPE_RST;
      push_code_r  <= PUSH_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      // writes to unknown indexes are dropped
      if (cfg_index == CFG_REPLY_TYPE) begin
        reply_code_r <= cfg_data;
      end
      if (cfg_index == CFG_PUSH_TYPE) begin
        push_code_r <= cfg_data;
      end
    end
  end

  assign cfg_o.reply_type_code = reply_code_r;
  assign cfg_o.push_type_code  = push_code_r;

endmodule

### rtl/core/wspd_in_stage.sv
// Input register stage for incoming octets.
module wspd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wspd_pkg::wspd_in_t in_data,
  input  logic               adv,
  output logic               item_valid,
  output wspd_pkg::wspd_in_t item
);
  import wspd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  wspd_in_t data_r;
  logic     take;

  // a held octet that cannot move on blocks the input
  assign in_stall = valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

### rtl/core/wspd_parse_core.sv
// Per-PDU parse state and the single-step octet classifier.
`include "wsp_pdu_deframer_macros.svh"

module wspd_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  wspd_pkg::wspd_in_t  item,
  input  wspd_pkg::wspd_cfg_t cfg_i,
  output wspd_pkg::wspd_out_t res
);
  import wspd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  id_r, id_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        top_r, top_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [7:0]  b;
  logic [2:0]  cnt_inc;
  logic [2:0]  fkind;
  logic        set_err;
  logic [2:0]  set_code;
  logic [2:0]  end_err;

  assign b = item.pdu_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TID;
      id_r    <= '0;
      kind_r  <= PDU_REPLY;
      acc_r   <= '0;
      cnt_r   <= '0;
      top_r   <= 1'b0;
      rem_r   <= '0;
      err_r   <= ERR_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      kind_r  <= kind_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      top_r   <= top_nxt;
      rem_r   <= rem_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    kind_nxt  = kind_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    top_nxt   = top_r;
    rem_nxt   = rem_r;
    err_nxt   = err_r;
    set_err   = 1'b0;
    set_code  = ERR_NONE;
    fkind     = KIND_DISCARD;
    cnt_inc   = cnt_r + 3'd1;
    end_err   = ERR_NONE;

    unique case (phase_r)
      PH_TID: begin
        fkind     = KIND_TID;
        id_nxt    = b;
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        fkind = KIND_TYPE;
        // reply wins when both codes match
        if (b == cfg_i.reply_type_code) begin
          kind_nxt  = PDU_REPLY;
          phase_nxt = PH_STATUS;
        end else if (b == cfg_i.push_type_code) begin
          kind_nxt  = PDU_PUSH;
          phase_nxt = PH_LEN;
        end else begin
          kind_nxt = PDU_REPLY;
          set_err  = 1'b1;
          set_code = ERR_TYPE;
        end
      end
      PH_STATUS: begin
        fkind     = KIND_STATUS;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        fkind = KIND_LEN;
        if (cnt_r == 3'd0) begin
          top_nxt = |b[6:4];
        end
        acc_nxt = {acc_r[24:0], b[6:0]};
        cnt_nxt = cnt_inc;
        if (b[7]) begin
          if (cnt_inc >= UV_MAX_OCTETS) begin
            set_err  = 1'b1;
            set_code = ERR_UINTVAR;
          end
        end else if (cnt_inc >= UV_MAX_OCTETS && top_nxt) begin
          set_err  = 1'b1;
          set_code = ERR_UINTVAR;
        end else begin
          rem_nxt   = acc_nxt;
          phase_nxt = (acc_nxt != 32'd0) ? PH_HDR : PH_BODY;
        end
      end
      PH_HDR: begin
        fkind   = KIND_HDR;
        rem_nxt = rem_r - 32'd1;
        if (rem_nxt == 32'd0) begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        fkind = KIND_BODY;
      end
      default: begin
        fkind     = KIND_DISCARD;
        phase_nxt = PH_DISCARD;
      end
    endcase

    if (set_err) begin
      if (err_r == ERR_NONE) begin
        err_nxt = set_code;
      end
      phase_nxt = PH_DISCARD;
    end

    // end-of-PDU checks on where the octet left the parser
    end_err = err_nxt;
    if (err_nxt == ERR_NONE) begin
      if (phase_nxt == PH_TYPE || phase_nxt == PH_STATUS || phase_nxt == PH_LEN) begin
        end_err = ERR_SHORT;
      end else if (phase_nxt == PH_HDR) begin
        end_err = ERR_OVERRUN;
      end
    end

    res.data_byte      = b;
    res.field_kind     = fkind;
    res.pdu_end        = item.last_byte;
    res.error_code     = ERR_NONE;
    res.pdu_kind       = PDU_REPLY;
    res.transaction_id = '0;
    res.header_length  = '0;

    if (item.last_byte) begin
      res.error_code     = end_err;
      res.pdu_kind       = kind_nxt;
      res.transaction_id = id_nxt;
      res.header_length  = acc_nxt;
      phase_nxt = PH_TID;
      id_nxt    = '0;
      kind_nxt  = PDU_REPLY;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      top_nxt   = 1'b0;
      rem_nxt   = '0;
      err_nxt   = ERR_NONE;
    end
  end

  `WSPD_ASSERT_NOW(a_err_discard, clk, rst_n, err_r != ERR_NONE, phase_r == PH_DISCARD, "error without discard phase")
  `WSPD_ASSERT_NOW(a_discard_err, clk, rst_n, phase_r == PH_DISCARD, err_r != ERR_NONE, "discard phase without error")
  `WSPD_ASSERT_NOW(a_hdr_rem, clk, rst_n, phase_r == PH_HDR, rem_r != 32'd0, "header phase with nothing left")
  `WSPD_ASSERT_NOW(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= UV_MAX_OCTETS, "uintvar octet count too high")
  `WSPD_ASSERT_NEXT(a_end_clear, clk, rst_n, step && item.last_byte, phase_r == PH_TID && err_r == ERR_NONE && cnt_r == 3'd0, "state not cleared after last octet")

endmodule

### rtl/core/wspd_out_stage.sv
// Result register with valid/stall handshake toward the consumer.
module wspd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  wspd_pkg::wspd_out_t res,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_stall,
  output wspd_pkg::wspd_out_t out_data
);
  import wspd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  wspd_out_t data_r;

  // the result register can load unless it holds a stalled transaction
  assign adv = item_valid && !(valid_r && out_stall);

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (adv) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/core/wsp_pdu_deframer.sv
// Top level of the connectionless WSP PDU deframer.
// Takes one received octet per clock unless stalled and returns one tagged result per
// octet, in order. Sustained rate is one octet per cycle while out_stall stays low; an
// accepted octet is captured in the input register, and its result is loaded into the
// result register once that register can take it. The parse state update that each
// octet makes for the next is the combinational step between the registers. A stalled
// result holds the input register, which stalls the input in the same cycle. Registers:
// index 0 reply type code (reset 4), index 1 push type code (reset 6); writes to other
// indexes are ignored and the port is always ready. Summary fields (error, kind, id,
// header length) are nonzero only on the result marked pdu_end.
module wsp_pdu_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wspd_pkg::wspd_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wspd_pkg::wspd_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import wspd_pkg::*;

  wspd_cfg_t cfg;
  wspd_in_t  item;
  wspd_out_t res;
  logic      item_valid;
  logic      adv;

  wspd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  wspd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  wspd_parse_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item),
    .cfg_i (cfg),
    .res   (res)
  );

  wspd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### tb/wsp_pdu_deframer_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the deframer: watches all channels, predicts tagged octets and compares.
module wsp_pdu_deframer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  wspd_pkg::wspd_in_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  wspd_pkg::wspd_out_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import wspd_pkg::*;

  localparam int MAX_PRINTED = 200;

  wspd_out_t   tagged_q[$];
  logic [7:0]  reply_code;
  logic [7:0]  push_code;

  phase_t      ph;
  logic [7:0]  id_q;
  logic        kind_q;
  logic [31:0] len_acc;
  logic [2:0]  len_cnt;
  logic        top_flag;
  logic [31:0] hdr_left;
  logic [2:0]  err_q;

  int n_fail = 0;

  assign fail_count = n_fail;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    // keep the log bounded if the block goes badly wrong
    if (n_fail < MAX_PRINTED)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic clear_pdu();
    ph       = PH_TID;
    id_q     = '0;
    kind_q   = PDU_REPLY;
    len_acc  = '0;
    len_cnt  = '0;
    top_flag = 1'b0;
    hdr_left = '0;
    err_q    = ERR_NONE;
  endtask

  // first error wins; the rest of the PDU is discarded
  task automatic raise_error(input logic [2:0] code);
    if (err_q == ERR_NONE) err_q = code;
    ph = PH_DISCARD;
  endtask

  task automatic parse_octet(input wspd_in_t it, output wspd_out_t res);
    logic [7:0] b;
    b = it.pdu_byte;
    res = '0;
    res.data_byte = b;
    res.pdu_end   = it.last_byte;
    case (ph)
      PH_TID: begin
        res.field_kind = KIND_TID;
        id_q = b;
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        res.field_kind = KIND_TYPE;
        if (b == reply_code) begin
          kind_q = PDU_REPLY;
          ph = PH_STATUS;
        end else if (b == push_code) begin
          kind_q = PDU_PUSH;
          ph = PH_LEN;
        end else begin
          kind_q = PDU_REPLY;
          raise_error(ERR_TYPE);
        end
      end
      PH_STATUS: begin
        res.field_kind = KIND_STATUS;
        ph = PH_LEN;
      end
      PH_LEN: begin
        res.field_kind = KIND_LEN;
        if (len_cnt == 3'd0) top_flag = |(b & 8'h70);
        len_acc = {len_acc[24:0], b[6:0]};
        len_cnt = len_cnt + 3'd1;
        if (b[7]) begin
          if (len_cnt >= UV_MAX_OCTETS) raise_error(ERR_UINTVAR);
        end else if (len_cnt >= UV_MAX_OCTETS && top_flag) begin
          raise_error(ERR_UINTVAR);
        end else begin
          hdr_left = len_acc;
          ph = (len_acc != 0) ? PH_HDR : PH_BODY;
        end
      end
      PH_HDR: begin
        res.field_kind = KIND_HDR;
        hdr_left = hdr_left - 32'd1;
        if (hdr_left == 0) ph = PH_BODY;
      end
      PH_BODY: begin
        res.field_kind = KIND_BODY;
      end
      default: begin
        res.field_kind = KIND_DISCARD;
        ph = PH_DISCARD;
      end
    endcase

    if (it.last_byte) begin
      if (err_q == ERR_NONE) begin
        if (ph == PH_TYPE || ph == PH_STATUS || ph == PH_LEN) err_q = ERR_SHORT;
        else if (ph == PH_HDR) err_q = ERR_OVERRUN;
      end
      res.error_code     = err_q;
      res.pdu_kind       = kind_q;
      res.transaction_id = id_q;
      res.header_length  = len_acc;
      clear_pdu();
    end
  endtask

  always @(posedge clk) begin : watch
    wspd_out_t want;
    wspd_out_t got;
    if (!rst_n) begin
      reply_code = REPLY_TYPE_RST;
      push_code  = PUSH_TYPE_RST;
      clear_pdu();
      tagged_q.delete();
    end else begin
      // compare before pushing, so a result can never match its own octet
      if (out_valid && !out_stall) begin
        got = out_data;
        if (tagged_q.size() == 0) begin
          flag_mismatch("result with no transaction waiting", 32'(got.data_byte), 32'd0);
        end else begin
          want = tagged_q.pop_front();
          if (got.data_byte !== want.data_byte)
            flag_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
          if (got.field_kind !== want.field_kind)
            flag_mismatch("field_kind", 32'(got.field_kind), 32'(want.field_kind));
          if (got.pdu_end !== want.pdu_end)
            flag_mismatch("pdu_end", 32'(got.pdu_end), 32'(want.pdu_end));
          if (got.error_code !== want.error_code)
            flag_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
          if (got.pdu_kind !== want.pdu_kind)
            flag_mismatch("pdu_kind", 32'(got.pdu_kind), 32'(want.pdu_kind));
          if (got.transaction_id !== want.transaction_id)
            flag_mismatch("transaction_id", 32'(got.transaction_id),
                          32'(want.transaction_id));
          if (got.header_length !== want.header_length)
            flag_mismatch("header_length", got.header_length, want.header_length);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REPLY_TYPE: reply_code = cfg_data;
          CFG_PUSH_TYPE:  push_code  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        parse_octet(in_data, want);
        tagged_q.push_back(want);
      end
    end
    pending <= tagged_q.size();
  end

endmodule

### tb/wsp_pdu_deframer_tb.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, PDU stimulus, stalls and verdict.
module wsp_pdu_deframer_tb;
  import wspd_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int CYCLE_LIMIT = 100000;
  localparam int IDLE_PCT    = 26;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hA5;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  wspd_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  wspd_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  int                   fail_count;
  int                   pending;

  int          cycles = 0;
  int          n_sent = 0;
  logic        calm = 1'b0;
  logic [7:0]  rc = REPLY_TYPE_RST;
  logic [7:0]  pc = PUSH_TYPE_RST;
  logic [7:0]  pdu_q[$];

  wsp_pdu_deframer dut (.*);

  wsp_pdu_deframer_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[wsp_pdu_deframer] ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic send_octet(input logic [7:0] b, input logic last);
    calm <= (n_sent >= 600 && n_sent < 800);
    while (!(n_sent >= 600 && n_sent < 800) && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      in_data.pdu_byte  <= 8'($urandom_range(0, 255));
      in_data.last_byte <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.pdu_byte  <= b;
    in_data.last_byte <= last;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic send_pdu();
    foreach (pdu_q[i]) send_octet(pdu_q[i], i == pdu_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_codes(input logic [7:0] reply_v, input logic [7:0] push_v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_REPLY_TYPE;
    cfg_data  <= reply_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PUSH_TYPE;
    cfg_data  <= push_v;
    do @(posedge clk); while (!cfg_ready);
    // writes to an unmapped index must be ignored
    cfg_index <= CFG_IDX_SPARE;
    cfg_data  <= 8'($urandom_range(0, 255));
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rc = reply_v;
    pc = push_v;
  endtask

  // type octet, plus a status octet for a Reply
  task automatic put_type();
    if (rc != pc && $urandom_range(0, 1)) begin
      pdu_q.push_back(pc);
    end else begin
      pdu_q.push_back(rc);
      pdu_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_pdu();
    int          style;
    int          pick;
    int          nhdr;
    int          cut;
    logic [31:0] hval;
    logic [31:0] rest;
    logic        cont;
    logic [7:0]  grp[$];
    logic [7:0]  odd;
    pdu_q.delete();
    style = $urandom_range(0, 99);
    pdu_q.push_back(8'($urandom_range(0, 255)));
    if (style < 82) begin
      put_type();
      pick = $urandom_range(0, 99);
      if (pick < 80) hval = $urandom_range(0, 6);
      else if (pick < 95) hval = $urandom_range(7, 160);
      else hval = $urandom;
      rest = hval;
      cont = 1'b0;
      do begin
        grp.push_front({cont, rest[6:0]});
        cont = 1'b1;
        rest = rest >> 7;
      end while (rest != 0);
      // leading zero groups are legal as long as the field stays within five octets
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(0, 5 - grp.size())) grp.push_front(8'h80);
      foreach (grp[i]) pdu_q.push_back(grp[i]);
      nhdr = (hval > 160) ? $urandom_range(0, 4) : hval;
      repeat (nhdr) pdu_q.push_back(8'($urandom_range(0, 255)));
      if (nhdr == hval) repeat ($urandom_range(0, 8)) pdu_q.push_back(8'($urandom_range(0, 255)));
      if (style >= 72) begin
        cut = $urandom_range(1, pdu_q.size());
        while (pdu_q.size() > cut) void'(pdu_q.pop_back());
      end
    end else if (style < 89) begin
      do odd = 8'($urandom_range(0, 255)); while (odd == rc || odd == pc);
      pdu_q.push_back(odd);
      repeat ($urandom_range(0, 4)) pdu_q.push_back(8'($urandom_range(0, 255)));
    end else if (style < 96) begin
      put_type();
      if ($urandom_range(0, 1)) begin
        repeat (5) pdu_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
      end else begin
        pdu_q.push_back({1'b1, 3'($urandom_range(1, 7)), 4'($urandom_range(0, 15))});
        repeat (3) pdu_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
        pdu_q.push_back(8'($urandom_range(0, 127)));
      end
      repeat ($urandom_range(0, 3)) pdu_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 8)) pdu_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_pdus(input int goal);
    while (n_sent < goal) begin
      build_pdu();
      send_pdu();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reply with empty header and one body octet
    pdu_q = '{8'h00, REPLY_TYPE_RST, 8'hFF, 8'h00, 8'hAB};
    send_pdu();
    // push whose header runs past the end of the PDU
    pdu_q = '{8'hFF, PUSH_TYPE_RST, 8'h03, 8'h7E, 8'h81};
    send_pdu();
    // unknown type, trailing octet discarded
    pdu_q = '{8'h5A, 8'h80, 8'h11};
    send_pdu();
    // PDU of a lone transaction id
    pdu_q = '{8'h01};
    send_pdu();
    // length field still continuing on its fifth octet
    pdu_q = '{8'h22, PUSH_TYPE_RST, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
    send_pdu();
    // five-octet length with high bits set in the first octet
    pdu_q = '{8'h33, PUSH_TYPE_RST, 8'hF0, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h44};
    send_pdu();

    random_pdus(ITEM_TARGET / 5);
    set_codes(8'h00, 8'hFF);
    random_pdus(2 * ITEM_TARGET / 5);
    set_codes(8'hFF, 8'h00);
    random_pdus(3 * ITEM_TARGET / 5);
    // equal codes: type octet always decodes as a Reply
    set_codes(8'h5C, 8'h5C);
    random_pdus(4 * ITEM_TARGET / 5);
    set_codes(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
    random_pdus(ITEM_TARGET);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[wsp_pdu_deframer] OK");
    end else begin
      $display("[wsp_pdu_deframer] ERROR");
    end
    $finish;
  end

endmodule

### wsp_pdu_deframer.f
+incdir+rtl/core
rtl/core/wspd_pkg.sv
rtl/core/wspd_cfg_regs.sv
rtl/core/wspd_in_stage.sv
rtl/core/wspd_parse_core.sv
rtl/core/wspd_out_stage.sv
rtl/core/wsp_pdu_deframer.sv
tb/wsp_pdu_deframer_checker.sv
tb/wsp_pdu_deframer_tb.sv
